### design/eqpx_pkg.sv
`timescale 1ns / 1ps

package eqpx_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SWITCH = 2'd1,
    OP_ABORT  = 2'd2,
    OP_SET    = 2'd3
  } op_t;

  typedef struct packed {
    logic       fading;
    logic [2:0] engine;
  } status_t;

  localparam int          ENGINE_W        = 3;
  localparam int          STATUS_W        = 4;
  localparam int          LEN_W           = 16;
  localparam logic [2:0]  ENGINE_LAST     = 3'd5;
  localparam logic [15:0] FADE_LENGTH_RST = 16'd441;
  localparam logic [15:0] FADE_LENGTH_MIN = 16'd16;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] ONE_Q30         = 64'd1073741824;
  localparam logic [63:0] HALF_Q15        = 64'd16384;
  localparam logic [63:0] GAIN_ONE        = 64'd32768;
  localparam logic [63:0] TAYLOR_DIV [8]  = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182, 64'd240};

  function automatic logic [ENGINE_W-1:0] normalize_engine(input logic [ENGINE_W-1:0] code);
    return (code <= ENGINE_LAST) ? code : '0;
  endfunction

  // Quarter-cosine gain in Q1.15 for a Q2.30 angle, 9-term series.
  function automatic logic [15:0] cos_q15(input logic [63:0] angle);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        g;
    x2   = (angle * angle) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int k = 0; k < 8; k++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[k];
      if ((k % 2) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    g = ($unsigned(sum) + HALF_Q15) >> 15;
    if (g > GAIN_ONE) begin
      g = GAIN_ONE;
    end
    return g[15:0];
  endfunction

endpackage

### design/equal_power_engine_crossfade.sv
`timescale 1ns / 1ps

// Equal-power crossfade between an outgoing and an incoming engine stream.
// Input channel: push/full; one item per transfer (op, engine_code and the two
// samples). Result channel: empty/pop; exactly one result per input item, in
// order, on mixed_sample, fading and shown_engine while empty is low.
// Configuration: cfg_valid/cfg_ready write fade_length; cfg_ready is always
// high. Write it only while the block holds no unfinished item.
// A sample taken during a fade passes the bit-serial index divider and then
// the two gain table reads and multiplies, which share one table port; other
// ops go straight to the result. One item is processed at a time: a new item
// is taken only after the result of the last one has gone into the output queue.
// A two-entry queue on the input and on the output lets both sides keep moving.
// Reset (rst, synchronous) clears the fade, selects engine 0 and loads
// fade_length with 441. When the receiver stalls, results hold in the output
// queue and the block stops after finishing the item in progress; full then
// rises once the input queue fills.
module equal_power_engine_crossfade #(
  parameter int GAIN_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic [2:0]                     engine_code,
  input  logic signed [SAMPLE_WIDTH-1:0] old_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
  input  logic                           pop,
  output logic                           empty,
  output logic signed [SAMPLE_WIDTH-1:0] mixed_sample,
  output logic                           fading,
  output logic [2:0]                     shown_engine,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [15:0]                    fade_length
);

  localparam int RES_W = SAMPLE_WIDTH + eqpx_pkg::STATUS_W;

  logic                           cmd_valid;
  logic                           cmd_ready;
  eqpx_pkg::op_t                  cmd_op;
  logic [2:0]                     cmd_engine;
  logic signed [SAMPLE_WIDTH-1:0] cmd_old;
  logic signed [SAMPLE_WIDTH-1:0] cmd_new;
  logic                           res_full;
  logic                           res_push;
  logic signed [SAMPLE_WIDTH-1:0] res_mixed;
  eqpx_pkg::status_t              res_status;
  logic [RES_W-1:0]               res_dout;
  eqpx_pkg::status_t              out_status;

  assign cfg_ready = 1'b1;

  eqpx_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .engine_code(engine_code),
    .old_sample (old_sample),
    .new_sample (new_sample),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (cmd_op),
    .cmd_engine (cmd_engine),
    .cmd_old    (cmd_old),
    .cmd_new    (cmd_new)
  );

  eqpx_back #(
    .GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (fade_length),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_engine(cmd_engine),
    .cmd_old   (cmd_old),
    .cmd_new   (cmd_new),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_mixed (res_mixed),
    .res_status(res_status)
  );

  eqpx_fifo #(
    .WIDTH(RES_W)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .din  ({res_status, res_mixed}),
    .pop  (pop),
    .empty(empty),
    .dout (res_dout)
  );

  assign out_status   = eqpx_pkg::status_t'(res_dout[RES_W-1:SAMPLE_WIDTH]);
  assign mixed_sample = res_dout[SAMPLE_WIDTH-1:0];
  assign fading       = out_status.fading;
  assign shown_engine = out_status.engine;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !res_push)
    else $error("two results in consecutive cycles");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> !res_push)
    else $error("command taken while a result is in transfer");

  a_empty_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> $past(pop))
    else $error("result queue drained without a pop");

endmodule

### design/eqpx_fifo.sv
`timescale 1ns / 1ps

module eqpx_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### design/eqpx_front.sv
`timescale 1ns / 1ps

module eqpx_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic [2:0]                     engine_code,
  input  logic signed [SAMPLE_WIDTH-1:0] old_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output eqpx_pkg::op_t                  cmd_op,
  output logic [2:0]                     cmd_engine,
  output logic signed [SAMPLE_WIDTH-1:0] cmd_old,
  output logic signed [SAMPLE_WIDTH-1:0] cmd_new
);

  localparam int CMD_W = 2 + eqpx_pkg::ENGINE_W + 2 * SAMPLE_WIDTH;

  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic             cmd_empty;

  // Normalize the engine code before it enters the queue.
  assign cmd_in = {op, eqpx_pkg::normalize_engine(engine_code), old_sample, new_sample};

  eqpx_fifo #(
    .WIDTH(CMD_W)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (cmd_in),
    .pop  (cmd_ready),
    .empty(cmd_empty),
    .dout (cmd_out)
  );

  assign cmd_valid  = !cmd_empty;
  assign cmd_op     = eqpx_pkg::op_t'(cmd_out[CMD_W-1 -: 2]);
  assign cmd_engine = cmd_out[CMD_W-3 -: eqpx_pkg::ENGINE_W];
  assign cmd_old    = cmd_out[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
  assign cmd_new    = cmd_out[SAMPLE_WIDTH-1:0];

endmodule

### design/eqpx_div.sv
`timescale 1ns / 1ps

module eqpx_div #(
  parameter int QW = 11,
  parameter int DW = 27
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 num,
  input  logic [eqpx_pkg::LEN_W-1:0]    den,
  output logic                          done,
  output logic [QW-1:0]                 quot
);

  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= DW'(den) << (QW - 1);
        cnt  <= CW'(QW - 1);
        quot <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          quot <= {quot[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

endmodule

### design/eqpx_back.sv
`timescale 1ns / 1ps

module eqpx_back #(
  parameter int GAIN_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [eqpx_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  eqpx_pkg::op_t                     cmd_op,
  input  logic [2:0]                        cmd_engine,
  input  logic signed [SAMPLE_WIDTH-1:0]    cmd_old,
  input  logic signed [SAMPLE_WIDTH-1:0]    cmd_new,
  input  logic                              res_full,
  output logic                              res_push,
  output logic signed [SAMPLE_WIDTH-1:0]    res_mixed,
  output eqpx_pkg::status_t                 res_status
);

  localparam int QW   = $clog2(GAIN_TABLE_DEPTH + 1);
  localparam int DW   = eqpx_pkg::LEN_W + QW;
  localparam int PW   = SAMPLE_WIDTH + 17;
  localparam int SUMW = SAMPLE_WIDTH + 18;
  localparam int RW   = SAMPLE_WIDTH + 3;
  localparam logic signed [RW-1:0]   SAT_MAX = RW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0]   SAT_MIN = ~SAT_MAX;
  localparam logic signed [SUMW-1:0] ROUND_HALF = SUMW'(16384);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD_OLD,
    S_RD_NEW,
    S_MUL_NEW,
    S_SUM,
    S_ROUND,
    S_PUT
  } state_t;

  state_t                     state;
  logic [15:0]                length_cfg;
  logic                       fade_active;
  logic [15:0]                position;
  logic [15:0]                total;
  logic [2:0]                 active_engine;
  logic [2:0]                 pending_engine;

  logic                       fade_active_next;
  logic [15:0]                position_next;
  logic [15:0]                total_next;
  logic [2:0]                 active_engine_next;
  logic [2:0]                 pending_engine_next;
  logic [15:0]                pos_step;
  logic                       mix_go;
  logic                       take;

  logic                       div_start;
  logic [DW-1:0]              div_num;
  logic [15:0]                div_den;
  logic                       div_done;
  logic [QW-1:0]              quot;

  logic [15:0]                gain_rom [GAIN_TABLE_DEPTH+1];
  logic [QW-1:0]              rom_addr;
  logic [15:0]                gain;

  logic signed [SAMPLE_WIDTH-1:0] old_q;
  logic signed [SAMPLE_WIDTH-1:0] new_q;
  logic signed [PW-1:0]       prod_old;
  logic signed [PW-1:0]       prod_new;
  logic signed [SUMW-1:0]     sum;
  logic signed [SUMW-1:0]     biased;
  logic signed [RW-1:0]       rounded;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  for (genvar i = 0; i <= GAIN_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] ANGLE = (eqpx_pkg::HALF_PI_Q30 * 64'(i)) / GAIN_TABLE_DEPTH;
    assign gain_rom[i] = eqpx_pkg::cos_q15(ANGLE);
  end

  assign rom_addr = (state == S_RD_NEW) ? (QW'(GAIN_TABLE_DEPTH) - quot) : quot;

  always_ff @(posedge clk) begin
    gain <= gain_rom[rom_addr];
  end

  eqpx_div #(
    .QW(QW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (quot)
  );

  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_ready && cmd_valid;
  assign res_push  = (state == S_PUT) && !res_full;

  always_comb begin
    fade_active_next    = fade_active;
    position_next       = position;
    total_next          = total;
    active_engine_next  = active_engine;
    pending_engine_next = pending_engine;
    mix_go              = 1'b0;
    pos_step            = (position < total) ? (position + 16'd1) : position;
    case (cmd_op)
      eqpx_pkg::OP_SAMPLE: begin
        if (fade_active) begin
          mix_go = 1'b1;
          if (pos_step >= total) begin
            active_engine_next = pending_engine;
            fade_active_next   = 1'b0;
            position_next      = '0;
            total_next         = '0;
          end else begin
            position_next = pos_step;
          end
        end
      end
      eqpx_pkg::OP_SWITCH: begin
        if (!(cmd_engine == active_engine && !fade_active)) begin
          pending_engine_next = cmd_engine;
          total_next          = (length_cfg < eqpx_pkg::FADE_LENGTH_MIN) ?
                                eqpx_pkg::FADE_LENGTH_MIN : length_cfg;
          position_next       = '0;
          fade_active_next    = 1'b1;
        end
      end
      eqpx_pkg::OP_ABORT: begin
        fade_active_next = 1'b0;
        position_next    = '0;
        total_next       = '0;
      end
      eqpx_pkg::OP_SET: begin
        fade_active_next    = 1'b0;
        position_next       = '0;
        total_next          = '0;
        active_engine_next  = cmd_engine;
        pending_engine_next = cmd_engine;
      end
      default: begin
        mix_go = 1'b0;
      end
    endcase
  end

  assign biased  = sum + ROUND_HALF;
  assign rounded = RW'(biased >>> 15);
  assign sat     = (rounded > SAT_MAX) ? SAT_MAX[SAMPLE_WIDTH-1:0] :
                   (rounded < SAT_MIN) ? SAT_MIN[SAMPLE_WIDTH-1:0] :
                   rounded[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      length_cfg     <= eqpx_pkg::FADE_LENGTH_RST;
      fade_active    <= 1'b0;
      position       <= '0;
      total          <= '0;
      active_engine  <= '0;
      pending_engine <= '0;
      div_start      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        length_cfg <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            fade_active       <= fade_active_next;
            position          <= position_next;
            total             <= total_next;
            active_engine     <= active_engine_next;
            pending_engine    <= pending_engine_next;
            res_status.fading <= fade_active_next;
            res_status.engine <= fade_active_next ? pending_engine_next : active_engine_next;
            old_q             <= cmd_old;
            new_q             <= cmd_new;
            if (mix_go) begin
              div_start <= 1'b1;
              div_num   <= DW'(position) * DW'(GAIN_TABLE_DEPTH);
              div_den   <= total;
              state     <= S_DIV;
            end else begin
              res_mixed <= (cmd_op == eqpx_pkg::OP_SAMPLE) ? cmd_old : '0;
              state     <= S_PUT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RD_OLD;
          end
        end
        S_RD_OLD: begin
          state <= S_RD_NEW;
        end
        S_RD_NEW: begin
          prod_old <= old_q * $signed({1'b0, gain});
          state    <= S_MUL_NEW;
        end
        S_MUL_NEW: begin
          prod_new <= new_q * $signed({1'b0, gain});
          state    <= S_SUM;
        end
        S_SUM: begin
          sum   <= SUMW'(prod_old) + SUMW'(prod_new);
          state <= S_ROUND;
        end
        S_ROUND: begin
          res_mixed <= sat;
          state     <= S_PUT;
        end
        S_PUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
